FILE: rtl/dhf_pkg.sv
// Shared constants and types for the depth hole-fill mode filter.
`timescale 1ns / 1ps
`default_nettype none
package dhf_pkg;
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int RING_SIZE  = 4 * MAX_WIDTH + 8;
  localparam int PTR_W      = $clog2(RING_SIZE);
  localparam int PIX_W      = 16;
  localparam int NB         = 24;
  localparam int NB_W       = $clog2(NB + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_W = 3'd0;
  localparam logic [2:0] CFG_FRAME_H = 3'd1;
  localparam logic [2:0] CFG_REG_X   = 3'd2;
  localparam logic [2:0] CFG_REG_Y   = 3'd3;
  localparam logic [2:0] CFG_REG_W   = 3'd4;
  localparam logic [2:0] CFG_REG_H   = 3'd5;
  localparam logic [2:0] CFG_IN_TH   = 3'd6;
  localparam logic [2:0] CFG_OUT_TH  = 3'd7;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [PTR_W-1:0] ptr_t;

  // sequencer to mode unit
  typedef struct packed {
    logic clr;
    logic push;
    logic scan;
  } mode_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/depth_hole_fill_mode_filter.sv
// Top level: raster counters, window sequencer and output register.
//
//  port group | dir | handshake        | payload
//  in_*       | in  | in_valid/in_stall | in_depth_in, in_flush
//  out_*      | out | out_valid/out_stall | out_depth_out, out_frame_last
//  cfg_*      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item that yields a result passes through the line store reads for the 25
// window positions through the single read port, a drain state, a scan over
// the distinct neighbor values and the output load. Synchronous active-low
// reset; the line store is not cleared.
// A stalled output word holds the sequencer in its final state.
`timescale 1ns / 1ps
`default_nettype none
module depth_hole_fill_mode_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_depth_in,
  input  wire logic        in_flush,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_depth_out,
  output logic             out_frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import dhf_pkg::*;

  localparam int AW = PTR_W + 2;
  localparam logic signed [AW-1:0] RING_S = AW'(RING_SIZE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // configuration
  logic [9:0] fw_r, fh_r, rw_r, rh_r;
  logic [8:0] rx_r, ry_r;
  logic [3:0] ith_r;
  logic [4:0] oth_r;

  // raster state
  logic [8:0]  in_col_r, out_col_r;
  logic [9:0]  in_row_r, out_row_r;
  logic [10:0] pend_r;
  ptr_t        wr_ptr_r, rd_ptr_r;

  // job state
  logic [2:0]  state_r;
  logic [8:0]  job_c_r;
  logic [9:0]  job_r_r;
  logic        job_last_r;
  logic [4:0]  k_r;
  logic [2:0]  dxc_r, dyc_r;
  logic signed [11:0] xs_r, ys_r;
  ptr_t        addr_r;
  logic        d_vld_r, d_use_r, d_center_r, d_inner_r;
  pix_t        cen_r;
  logic [3:0]  inner_r;
  logic [4:0]  outer_r;
  logic        out_valid_r, out_last_r;
  pix_t        out_depth_r;

  // accept-side decode
  logic [9:0]  w, h;
  logic        restart, accept, do_write, go_out, last, end_frame;
  logic [8:0]  ic0, ic1, oc0, oc2;
  logic [9:0]  ir0, ir1, or0, or2;
  logic [10:0] pend0, pend1, pend2;
  logic signed [AW-1:0] ainit, astep, anext;
  logic [10:0] xlim, ylim, rxw, ryh;
  logic        use_k, inner_k, center_k, push, fill, pass, in_reg;
  logic        can_load;
  pix_t        rdata, mode_val, result;
  logic        mode_busy;
  mode_ctl_t   mctl;

  always_comb begin
    w = (fw_r == 10'd0) ? 10'd1 : (fw_r > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : fw_r;
    h = (fh_r == 10'd0) ? 10'd1 : (fh_r > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : fh_r;
    restart = (out_row_r >= h);
    ic0   = restart ? '0 : in_col_r;
    ir0   = restart ? '0 : in_row_r;
    oc0   = restart ? '0 : out_col_r;
    or0   = restart ? '0 : out_row_r;
    pend0 = restart ? '0 : pend_r;
    accept   = in_valid && !in_stall;
    do_write = (ir0 < h) && !in_flush;
    // input side step
    pend1 = do_write ? pend0 + 11'd1 : pend0;
    ic1 = ic0;
    ir1 = ir0;
    if (do_write) begin
      if ({1'b0, ic0} + 10'd1 >= w) begin
        ic1 = '0;
        ir1 = ir0 + 10'd1;
      end else begin
        ic1 = ic0 + 9'd1;
      end
    end
    go_out = (ir0 >= h) || (do_write && pend1 > ({w, 1'b0} + 11'd2));
    // output side step
    last  = ({1'b0, or0} + 11'd1 >= {1'b0, h}) && ({1'b0, oc0} + 10'd1 >= w);
    pend2 = (pend1 != 11'd0) ? pend1 - 11'd1 : pend1;
    oc2 = oc0 + 9'd1;
    or2 = or0;
    if ({1'b0, oc0} + 10'd1 >= w) begin
      oc2 = '0;
      or2 = or0 + 10'd1;
    end
    end_frame = (or2 >= h);
    // first window address: centre minus two rows and two columns
    ainit = $signed({2'b0, rd_ptr_r}) - $signed({{(AW-11){1'b0}}, w, 1'b0})
            - AW'(2);
    if (ainit < 0) begin
      ainit = ainit + RING_S;
    end
  end

  // window walk address step
  always_comb begin
    astep = (dxc_r == 3'd4) ? $signed({{(AW-10){1'b0}}, w}) - AW'(4) : AW'(1);
    anext = $signed({2'b0, addr_r}) + astep;
    if (anext < 0) begin
      anext = anext + RING_S;
    end else if (anext >= RING_S) begin
      anext = anext - RING_S;
    end
  end

  // neighbor bounds and ring class
  always_comb begin
    rxw  = {2'b0, rx_r} + {1'b0, rw_r};
    ryh  = {2'b0, ry_r} + {1'b0, rh_r};
    xlim = (rxw > {1'b0, w}) ? {1'b0, w} : rxw;
    ylim = (ryh > {1'b0, h}) ? {1'b0, h} : ryh;
    center_k = (dxc_r == 3'd2) && (dyc_r == 3'd2);
    inner_k  = (dxc_r >= 3'd1) && (dxc_r <= 3'd3) && (dyc_r >= 3'd1) && (dyc_r <= 3'd3);
    use_k    = !xs_r[11] && !ys_r[11] && (xs_r < $signed({1'b0, xlim}))
               && (ys_r < $signed({1'b0, ylim})) && !center_k;
    in_reg   = ({2'b0, job_c_r} >= {2'b0, rx_r}) && ({2'b0, job_c_r} < rxw)
               && ({1'b0, job_r_r} >= {2'b0, ry_r}) && ({1'b0, job_r_r} < ryh);
    fill     = ({1'b0, inner_r} >= {1'b0, ith_r}) || (outer_r >= oth_r);
    pass     = (cen_r != '0) || !in_reg;
    result   = pass ? cen_r : (fill ? mode_val : '0);
    push     = d_vld_r && d_use_r && (rdata != '0);
    mctl.clr  = accept && go_out;
    mctl.push = push;
    mctl.scan = (state_r == S_DRAIN);
    can_load  = !out_valid_r || !out_stall;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= 10'd512;
      fh_r  <= 10'd512;
      rx_r  <= '0;
      ry_r  <= '0;
      rw_r  <= 10'd512;
      rh_r  <= 10'd512;
      ith_r <= 4'd3;
      oth_r <= 5'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_W: fw_r  <= cfg_data;
        CFG_FRAME_H: fh_r  <= cfg_data;
        CFG_REG_X:   rx_r  <= cfg_data[8:0];
        CFG_REG_Y:   ry_r  <= cfg_data[8:0];
        CFG_REG_W:   rw_r  <= cfg_data;
        CFG_REG_H:   rh_r  <= cfg_data;
        CFG_IN_TH:   ith_r <= cfg_data[3:0];
        CFG_OUT_TH:  oth_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // raster counters, ring pointers and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      pend_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      k_r         <= '0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_vld_r <= (state_r == S_RUN);
      // output word: load when free, drop once taken
      if (state_r == S_OUT && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (do_write) begin
              wr_ptr_r <= (wr_ptr_r == ptr_t'(RING_SIZE - 1)) ? '0
                          : wr_ptr_r + ptr_t'(1);
            end
            if (go_out) begin
              rd_ptr_r <= (rd_ptr_r == ptr_t'(RING_SIZE - 1)) ? '0
                          : rd_ptr_r + ptr_t'(1);
              if (end_frame) begin
                in_col_r  <= '0;
                in_row_r  <= '0;
                out_col_r <= '0;
                out_row_r <= '0;
                pend_r    <= '0;
              end else begin
                in_col_r  <= ic1;
                in_row_r  <= ir1;
                out_col_r <= oc2;
                out_row_r <= or2;
                pend_r    <= pend2;
              end
              k_r     <= '0;
              state_r <= S_RUN;
            end else begin
              in_col_r  <= ic1;
              in_row_r  <= ir1;
              out_col_r <= oc0;
              out_row_r <= or0;
              pend_r    <= pend1;
            end
          end
        end
        S_RUN: begin
          k_r <= k_r + 5'd1;
          if (k_r == 5'(NB)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_SCAN;
        S_SCAN: begin
          if (!mode_busy) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // window walk and neighbor tallies
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && go_out) begin
      job_c_r    <= oc0;
      job_r_r    <= or0;
      job_last_r <= last;
      addr_r     <= ainit[PTR_W-1:0];
      xs_r       <= $signed({3'b0, oc0}) - 12'sd2;
      ys_r       <= $signed({2'b0, or0}) - 12'sd2;
      dxc_r      <= '0;
      dyc_r      <= '0;
      inner_r    <= '0;
      outer_r    <= '0;
      cen_r      <= '0;
    end else begin
      if (state_r == S_RUN) begin
        addr_r <= anext[PTR_W-1:0];
        if (dxc_r == 3'd4) begin
          dxc_r <= '0;
          dyc_r <= dyc_r + 3'd1;
          xs_r  <= $signed({3'b0, job_c_r}) - 12'sd2;
          ys_r  <= ys_r + 12'sd1;
        end else begin
          dxc_r <= dxc_r + 3'd1;
          xs_r  <= xs_r + 12'sd1;
        end
      end
      if (d_vld_r && d_center_r) begin
        cen_r <= rdata;
      end
      if (push) begin
        if (d_inner_r) begin
          inner_r <= inner_r + 4'd1;
        end else begin
          outer_r <= outer_r + 5'd1;
        end
      end
    end
    d_use_r    <= use_k;
    d_inner_r  <= inner_k;
    d_center_r <= center_k;
    if (state_r == S_OUT && can_load) begin
      out_depth_r <= result;
      out_last_r  <= job_last_r;
    end
  end

  dhf_line_mem u_mem (
    .clk   (clk),
    .we    (accept && state_r == S_IDLE && do_write),
    .waddr (wr_ptr_r),
    .wdata (in_depth_in),
    .raddr (addr_r),
    .rdata (rdata)
  );

  dhf_mode_unit u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mctl),
    .value    (rdata),
    .busy     (mode_busy),
    .mode_val (mode_val)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_depth_out  = out_depth_r;
  assign out_frame_last = out_last_r;
endmodule
`default_nettype wire

FILE: rtl/dhf_line_mem.sv
// Ring line store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dhf_line_mem (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire dhf_pkg::ptr_t waddr,
  input  wire dhf_pkg::pix_t wdata,
  input  wire dhf_pkg::ptr_t raddr,
  output dhf_pkg::pix_t      rdata
);
  import dhf_pkg::*;

  pix_t mem [RING_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/dhf_mode_unit.sv
// Distinct-value table with counts and a serial argmax scan.
`timescale 1ns / 1ps
`default_nettype none
module dhf_mode_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dhf_pkg::mode_ctl_t ctl,
  input  wire dhf_pkg::pix_t     value,
  output logic                   busy,
  output dhf_pkg::pix_t          mode_val
);
  import dhf_pkg::*;

  pix_t            vals_r [NB];
  logic [NB_W-1:0] cnts_r [NB];
  logic [NB_W-1:0] nvals_r;
  logic [NB_W-1:0] j_r;
  logic [NB_W-1:0] best_cnt_r;
  pix_t            best_r;
  logic            scan_r;
  logic [NB-1:0]   match;
  logic            hit;

  // compare against every stored value at once
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      match[i] = (NB_W'(i) < nvals_r) && (vals_r[i] == value);
    end
    hit = |match;
  end

  // table entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < NB; i++) begin
      if (ctl.push) begin
        if (match[i]) begin
          cnts_r[i] <= cnts_r[i] + NB_W'(1);
        end else if (!hit && nvals_r == NB_W'(i)) begin
          vals_r[i] <= value;
          cnts_r[i] <= NB_W'(1);
        end
      end
    end
  end

  // fill count and scan; first entry wins ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvals_r    <= '0;
      scan_r     <= 1'b0;
      j_r        <= '0;
      best_cnt_r <= '0;
      best_r     <= '0;
    end else begin
      if (ctl.clr) begin
        nvals_r <= '0;
      end else if (ctl.push && !hit) begin
        nvals_r <= nvals_r + NB_W'(1);
      end
      if (ctl.scan) begin
        scan_r     <= 1'b1;
        j_r        <= '0;
        best_cnt_r <= '0;
        best_r     <= '0;
      end else if (scan_r) begin
        if (j_r < nvals_r) begin
          if (cnts_r[j_r] > best_cnt_r) begin
            best_cnt_r <= cnts_r[j_r];
            best_r     <= vals_r[j_r];
          end
          j_r <= j_r + NB_W'(1);
        end else begin
          scan_r <= 1'b0;
        end
      end
    end
  end

  assign busy     = scan_r;
  assign mode_val = best_r;
endmodule
`default_nettype wire
